### rtl/core/gksb_pkg.sv
package gksb_pkg;

  localparam int KEY_DOMAIN_DEF = 1024;
  localparam int NUM_SLOTS_DEF  = 256;
  localparam int GEN_WIDTH_DEF  = 32;
  localparam int KEY_DIMS_DEF   = 3;

  localparam int NUM_DIMS = 3;
  localparam int MIN_W    = 32;
  localparam int CARD_W   = 11;
  localparam int SIU_W    = 9;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_BIND     = 3'd0,
    ACT_VALIDATE = 3'd1,
    ACT_SEAL     = 3'd2,
    ACT_EVICT    = 3'd3,
    ACT_CLOSE    = 3'd4,
    ACT_ABORT    = 3'd5,
    ACT_QUERY    = 3'd6,
    ACT_NOP      = 3'd7
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 4'd0,
    ST_RANGE    = 4'd1,
    ST_LATE     = 4'd2,
    ST_CLOSED   = 4'd3,
    ST_DISTINCT = 4'd4,
    ST_LIVE     = 4'd5,
    ST_ABORTED  = 4'd6,
    ST_STALE    = 4'd7,
    ST_NOT_DONE = 4'd8,
    ST_GEN_EXH  = 4'd9,
    ST_INTERNAL = 4'd10
  } status_t;

  localparam logic [1:0] KS_NEVER  = 2'd0;
  localparam logic [1:0] KS_ACTIVE = 2'd1;
  localparam logic [1:0] KS_DONE   = 2'd2;

  typedef enum logic [2:0] {
    REG_MIN0  = 3'd0,
    REG_CARD0 = 3'd1,
    REG_MIN1  = 3'd2,
    REG_CARD1 = 3'd3,
    REG_MIN2  = 3'd4,
    REG_CARD2 = 3'd5,
    REG_SIU   = 3'd6,
    REG_NONE  = 3'd7
  } reg_addr_t;

  typedef struct packed {
    logic [MIN_W-1:0]  min;
    logic [CARD_W-1:0] card;
  } dim_cfg_t;

endpackage

### rtl/core/gksb_front.sv
module gksb_front
  import gksb_pkg::*;
#(
  parameter int KEY_DOMAIN = KEY_DOMAIN_DEF,
  parameter int KEY_DIMS   = KEY_DIMS_DEF,
  parameter int GEN_WIDTH  = GEN_WIDTH_DEF,
  parameter int SLOT_W     = 8,
  parameter int IDX_W      = 10,
  parameter int ENTRY_W    = ACT_W + SLOT_W + GEN_WIDTH + IDX_W + STAT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [ACT_W-1:0]     action,
  input  logic [MIN_W-1:0]     key_first,
  input  logic [MIN_W-1:0]     key_second,
  input  logic [MIN_W-1:0]     key_third,
  input  logic [SLOT_W-1:0]    token_slot,
  input  logic [GEN_WIDTH-1:0] token_generation,
  input  dim_cfg_t             dims [NUM_DIMS],
  input  logic                 q_full,
  output logic                 front_busy,
  output logic                 push,
  output logic [ENTRY_W-1:0]   push_data
);

  localparam int PART_W = 2 * CARD_W + 1;
  localparam int FULL_W = 3 * CARD_W + 2;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_CHK  = 4'b0010,
    F_MUL1 = 4'b0100,
    F_MUL2 = 4'b1000
  } fstate_t;

  fstate_t               fstate;
  logic [ACT_W-1:0]      act_r;
  logic [SLOT_W-1:0]     ts_r;
  logic [GEN_WIDTH-1:0]  tg_r;
  logic [MIN_W-1:0]      key_r [NUM_DIMS];
  logic [CARD_W-1:0]     off_r [NUM_DIMS];
  logic                  in_range_r;
  logic [PART_W-1:0]     part_r;

  logic [MIN_W:0]        diff_c [NUM_DIMS];
  logic [CARD_W-1:0]     off_c  [NUM_DIMS];
  logic [CARD_W-1:0]     card_e [NUM_DIMS];
  logic                  ok_c;
  logic [FULL_W-1:0]     full_c;
  logic [STAT_W-1:0]     istat_c;

  // Offsets per dimension; dimensions past KEY_DIMS act as radix one.
  always_comb begin
    ok_c = 1'b1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      diff_c[d] = {1'b0, key_r[d]} - {1'b0, dims[d].min};
      if (d < KEY_DIMS) begin
        off_c[d]  = diff_c[d][CARD_W-1:0];
        card_e[d] = dims[d].card;
        if (diff_c[d][MIN_W] ||
            diff_c[d][MIN_W-1:0] >= {{(MIN_W-CARD_W){1'b0}}, dims[d].card}) begin
          ok_c = 1'b0;
        end
      end else begin
        off_c[d]  = '0;
        card_e[d] = CARD_W'(1);
      end
    end
  end

  always_comb begin
    full_c = FULL_W'(part_r) * FULL_W'(card_e[2]) + FULL_W'(off_r[2]);
    if (!in_range_r) begin
      istat_c = ST_RANGE;
    end else if (full_c >= FULL_W'(KEY_DOMAIN)) begin
      istat_c = ST_INTERNAL;
    end else begin
      istat_c = ST_OK;
    end
  end

  assign front_busy = (fstate != F_IDLE);
  assign push       = (fstate == F_MUL2) && !q_full;
  assign push_data  = {act_r, ts_r, tg_r, full_c[IDX_W-1:0], istat_c};

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      unique case (fstate)
        F_IDLE: if (accept) fstate <= F_CHK;
        F_CHK:  fstate <= F_MUL1;
        F_MUL1: fstate <= F_MUL2;
        F_MUL2: if (!q_full) fstate <= F_IDLE;
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && accept) begin
      act_r    <= action;
      ts_r     <= token_slot;
      tg_r     <= token_generation;
      key_r[0] <= key_first;
      key_r[1] <= key_second;
      key_r[2] <= key_third;
    end
    if (fstate == F_CHK) begin
      off_r      <= off_c;
      in_range_r <= ok_c;
    end
    if (fstate == F_MUL1) begin
      part_r <= PART_W'(off_r[0]) * PART_W'(card_e[1]) + PART_W'(off_r[1]);
    end
  end

endmodule

### rtl/core/gksb_queue.sv
module gksb_queue
  import gksb_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         q_empty,
  output logic         q_full
);

  logic [W-1:0] ent [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign pop_data = ent[rd_ptr];
  assign q_empty  = (count == 2'd0);
  assign q_full   = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_data;
  end

endmodule

### rtl/core/gksb_back.sv
module gksb_back
  import gksb_pkg::*;
#(
  parameter int KEY_DOMAIN = KEY_DOMAIN_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int GEN_WIDTH  = GEN_WIDTH_DEF,
  parameter int SLOT_W     = 8,
  parameter int IDX_W      = 10,
  parameter int LIVE_W     = 9,
  parameter int CNT_W      = 11,
  parameter int ENTRY_W    = ACT_W + SLOT_W + GEN_WIDTH + IDX_W + STAT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [ENTRY_W-1:0]   q_data,
  input  logic [SIU_W-1:0]     siu,
  output logic                 pop,
  output logic                 clearing,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [SLOT_W-1:0]    granted_slot,
  output logic [GEN_WIDTH-1:0] granted_generation,
  output logic [IDX_W-1:0]     dense_key_index,
  output logic [LIVE_W-1:0]    live_count,
  output logic [CNT_W-1:0]     ever_bound_count,
  output logic [CNT_W-1:0]     completed_count,
  output logic                 keys_closed_flag,
  output logic                 aborted_flag
);

  localparam int LO_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int CLR_N = (KEY_DOMAIN > NUM_SLOTS) ? KEY_DOMAIN : NUM_SLOTS;
  localparam int CLR_W = $clog2(CLR_N + 1);
  localparam logic [GEN_WIDTH-1:0] GEN_MAX = {GEN_WIDTH{1'b1}};

  typedef struct packed {
    logic [1:0]           state;
    logic [SLOT_W-1:0]    slot;
    logic [GEN_WIDTH-1:0] gen;
  } key_rec_t;

  typedef struct packed {
    logic                 is_free;
    logic                 link_valid;
    logic [LO_W-1:0]      lo;
    logic [GEN_WIDTH-1:0] gen;
  } slot_rec_t;

  typedef enum logic [4:0] {
    B_CLEAR = 5'b00001,
    B_IDLE  = 5'b00010,
    B_RD1   = 5'b00100,
    B_RD2   = 5'b01000,
    B_EXEC  = 5'b10000
  } bstate_t;

  bstate_t bstate;

  key_rec_t  key_mem  [KEY_DOMAIN];
  slot_rec_t slot_mem [NUM_SLOTS];
  key_rec_t  key_rd;
  slot_rec_t slot_rd;

  logic                  k_re, s_re, k_we, s_we;
  logic [IDX_W-1:0]      k_raddr, k_waddr;
  logic [SLOT_W-1:0]     s_raddr, s_waddr;
  key_rec_t              k_wdata;
  slot_rec_t             s_wdata;

  logic [ENTRY_W-1:0]    ent;
  logic [ACT_W-1:0]      e_act;
  logic [SLOT_W-1:0]     e_ts;
  logic [GEN_WIDTH-1:0]  e_tg;
  logic [IDX_W-1:0]      e_idx;
  logic [STAT_W-1:0]     e_istat;

  logic [CLR_W-1:0]      clr_cnt;
  logic [SLOT_W-1:0]     head, head_next;
  logic                  head_valid, head_valid_next;
  logic [LIVE_W-1:0]     live, live_next;
  logic [CNT_W-1:0]      ever, ever_next, sealed, sealed_next;
  logic                  closed, closed_next, aborted, aborted_next;
  logic [LIVE_W-1:0]     eff;

  logic [STAT_W-1:0]     st;
  logic [STAT_W-1:0]     tok_st;
  logic [SLOT_W-1:0]     gs;
  logic [GEN_WIDTH-1:0]  gg;
  logic                  idx_ok;
  logic [1:0]            want;
  logic [STAT_W-1:0]     bad;
  logic                  ex_k_we, ex_s_we;
  logic [IDX_W-1:0]      ex_k_addr;
  logic [SLOT_W-1:0]     ex_s_addr;
  key_rec_t              ex_k_data;
  slot_rec_t             ex_s_data;

  assign {e_act, e_ts, e_tg, e_idx, e_istat} = ent;
  assign eff      = (32'(siu) > 32'(NUM_SLOTS)) ? LIVE_W'(NUM_SLOTS) : LIVE_W'(siu);
  assign clearing = (bstate == B_CLEAR);
  assign pop      = (bstate == B_IDLE) && !q_empty;

  // Shared token check for validate, seal and evict.
  always_comb begin
    want = (e_act == ACT_EVICT) ? KS_DONE : KS_ACTIVE;
    bad  = (e_act == ACT_EVICT) ? ST_NOT_DONE : ST_STALE;
    if (aborted) begin
      tok_st = ST_ABORTED;
    end else if (e_tg == '0 || 32'(e_ts) >= 32'(eff)) begin
      tok_st = ST_STALE;
    end else if (slot_rd.is_free || slot_rd.gen != e_tg ||
                 32'(slot_rd.lo) >= 32'(KEY_DOMAIN)) begin
      tok_st = ST_STALE;
    end else if (key_rd.state != want || key_rd.slot != e_ts || key_rd.gen != e_tg) begin
      tok_st = bad;
    end else begin
      tok_st = ST_OK;
    end
  end

  always_comb begin
    st              = ST_OK;
    gs              = '0;
    gg              = '0;
    idx_ok          = 1'b0;
    head_next       = head;
    head_valid_next = head_valid;
    live_next       = live;
    ever_next       = ever;
    sealed_next     = sealed;
    closed_next     = closed;
    aborted_next    = aborted;
    ex_k_we         = 1'b0;
    ex_s_we         = 1'b0;
    ex_k_addr       = e_idx;
    ex_s_addr       = e_ts;
    ex_k_data       = key_rd;
    ex_s_data       = slot_rd;
    unique case (e_act)
      ACT_BIND: begin
        if (aborted) begin
          st = ST_ABORTED;
        end else if (e_istat != ST_OK) begin
          st = e_istat;
        end else if (key_rd.state > KS_DONE) begin
          st = ST_INTERNAL;
        end else if (key_rd.state == KS_ACTIVE) begin
          if (32'(key_rd.slot) >= 32'(eff) || slot_rd.is_free ||
              32'(slot_rd.lo) != 32'(e_idx) || slot_rd.gen != key_rd.gen) begin
            st = ST_INTERNAL;
          end else begin
            gs = key_rd.slot;
            gg = key_rd.gen;
          end
        end else if (key_rd.state == KS_DONE) begin
          st = ST_LATE;
        end else if (closed) begin
          st = ST_CLOSED;
        end else if (32'(ever) >= 32'(KEY_DOMAIN)) begin
          st = ST_DISTINCT;
        end else if (32'(live) >= 32'(eff) || !head_valid) begin
          st = ST_LIVE;
        end else if (32'(head) >= 32'(eff)) begin
          st = ST_INTERNAL;
        end else if (!slot_rd.is_free || slot_rd.gen == '0 ||
                     (slot_rd.link_valid && 32'(slot_rd.lo) >= 32'(eff))) begin
          st = ST_INTERNAL;
        end else begin
          head_valid_next   = slot_rd.link_valid;
          head_next         = slot_rd.link_valid ? slot_rd.lo[SLOT_W-1:0] : '0;
          ex_s_we           = 1'b1;
          ex_s_addr         = head;
          ex_s_data.is_free    = 1'b0;
          ex_s_data.link_valid = 1'b0;
          ex_s_data.lo         = LO_W'(e_idx);
          ex_k_we           = 1'b1;
          ex_k_data.state   = KS_ACTIVE;
          ex_k_data.slot    = head;
          ex_k_data.gen     = slot_rd.gen;
          ever_next         = ever + CNT_W'(1);
          live_next         = live + LIVE_W'(1);
          gs                = head;
          gg                = slot_rd.gen;
        end
        idx_ok = (st == ST_OK) || (st == ST_LATE) || (st == ST_CLOSED) ||
                 (st == ST_DISTINCT) || (st == ST_LIVE);
      end
      ACT_VALIDATE: st = tok_st;
      ACT_SEAL: begin
        st = tok_st;
        if (tok_st == ST_OK) begin
          ex_k_we         = 1'b1;
          ex_k_addr       = slot_rd.lo[IDX_W-1:0];
          ex_k_data.state = KS_DONE;
          sealed_next     = sealed + CNT_W'(1);
        end
      end
      ACT_EVICT: begin
        if (tok_st != ST_OK) begin
          st = tok_st;
        end else if (slot_rd.gen >= GEN_MAX) begin
          st = ST_GEN_EXH;
        end else if (live == '0) begin
          st = ST_INTERNAL;
        end else if (head_valid && 32'(head) >= 32'(eff)) begin
          st = ST_INTERNAL;
        end else begin
          ex_s_we              = 1'b1;
          ex_s_data.gen        = slot_rd.gen + GEN_WIDTH'(1);
          ex_s_data.is_free    = 1'b1;
          ex_s_data.link_valid = head_valid;
          ex_s_data.lo         = head_valid ? LO_W'(head) : '0;
          head_next            = e_ts;
          head_valid_next      = 1'b1;
          live_next            = live - LIVE_W'(1);
        end
      end
      ACT_CLOSE: begin
        if (aborted) begin
          st = ST_ABORTED;
        end else if (closed) begin
          st = ST_CLOSED;
        end else begin
          closed_next = 1'b1;
        end
      end
      ACT_ABORT: begin
        closed_next  = 1'b1;
        aborted_next = 1'b1;
      end
      ACT_QUERY: begin
        st     = e_istat;
        idx_ok = (e_istat == ST_OK);
      end
      default: st = ST_OK;
    endcase
  end

  // Memory port selection: clearing sweep, reads in RD1/RD2, writes in EXEC.
  always_comb begin
    k_re    = 1'b0;
    s_re    = 1'b0;
    k_raddr = e_idx;
    s_raddr = e_ts;
    k_we    = 1'b0;
    s_we    = 1'b0;
    k_waddr = ex_k_addr;
    s_waddr = ex_s_addr;
    k_wdata = ex_k_data;
    s_wdata = ex_s_data;
    unique case (bstate)
      B_CLEAR: begin
        k_we    = (32'(clr_cnt) < 32'(KEY_DOMAIN));
        s_we    = (32'(clr_cnt) < 32'(NUM_SLOTS));
        k_waddr = clr_cnt[IDX_W-1:0];
        s_waddr = clr_cnt[SLOT_W-1:0];
        k_wdata = '0;
        s_wdata.is_free    = 1'b1;
        s_wdata.link_valid = (32'(clr_cnt) + 32'd1 < 32'(NUM_SLOTS));
        s_wdata.lo         = s_wdata.link_valid ? LO_W'(clr_cnt + CLR_W'(1)) : '0;
        s_wdata.gen        = GEN_WIDTH'(1);
      end
      B_RD1: begin
        k_re = 1'b1;
        s_re = 1'b1;
      end
      B_RD2: begin
        if (e_act == ACT_BIND) begin
          s_re    = 1'b1;
          s_raddr = (key_rd.state == KS_ACTIVE) ? key_rd.slot : head;
        end else begin
          k_re    = 1'b1;
          k_raddr = slot_rd.lo[IDX_W-1:0];
        end
      end
      B_EXEC: begin
        k_we = ex_k_we;
        s_we = ex_s_we;
      end
      default: begin
        k_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (k_we) key_mem[k_waddr] <= k_wdata;
    if (k_re) key_rd <= key_mem[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    if (s_re) slot_rd <= slot_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate     <= B_CLEAR;
      clr_cnt    <= '0;
      head       <= '0;
      head_valid <= 1'b1;
      live       <= '0;
      ever       <= '0;
      sealed     <= '0;
      closed     <= 1'b0;
      aborted    <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (bstate)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (32'(clr_cnt) == CLR_N - 1) bstate <= B_IDLE;
        end
        B_IDLE: if (!q_empty) bstate <= B_RD1;
        B_RD1:  bstate <= B_RD2;
        B_RD2:  bstate <= B_EXEC;
        B_EXEC: begin
          bstate     <= B_IDLE;
          done       <= 1'b1;
          head       <= head_next;
          head_valid <= head_valid_next;
          live       <= live_next;
          ever       <= ever_next;
          sealed     <= sealed_next;
          closed     <= closed_next;
          aborted    <= aborted_next;
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= q_data;
    if (bstate == B_EXEC) begin
      status             <= st;
      granted_slot       <= gs;
      granted_generation <= gg;
      dense_key_index    <= idx_ok ? e_idx : '0;
      live_count         <= live_next;
      ever_bound_count   <= ever_next;
      completed_count    <= sealed_next;
      keys_closed_flag   <= closed_next;
      aborted_flag       <= aborted_next;
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(bstate == B_EXEC))
    else $error("result strobe without an execute cycle");

  a_live_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(live) <= 32'(NUM_SLOTS))
    else $error("live key count beyond slot count");

  a_live_changes_in_exec: assert property (@(posedge clk) disable iff (rst)
    !$stable(live) |-> $past(bstate == B_EXEC))
    else $error("live key count changed outside execute");

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("queue popped during clearing sweep");

endmodule

### rtl/core/generational_key_slot_binder_core.sv
// Generational key-to-slot binder. An item is accepted when start is high and busy is low.
// The front end takes an item through capture, per-dimension range check and two
// multiplies for the mixed-radix index (the first registered, the second feeding the queue
// write), then hands it to a two-entry queue, waiting while it is full; the back end takes
// it through dequeue, key/slot record read, dependent second record read through the
// single read port of each memory, then execute and write back. The front end can accept
// a new item while the back end still works on earlier ones. Each result appears on the
// output ports, marked by done for exactly one cycle. The receiver cannot stall: every
// result must be taken in the cycle done is high. After reset the block runs a clearing
// sweep over max(KEY_DOMAIN, NUM_SLOTS) addresses (1024 by default) that initializes the
// key and slot records; busy stays high for that time, but configuration writes over the
// APB port are taken throughout. Configuration must only be written while the block is idle.
module generational_key_slot_binder_core
  import gksb_pkg::*;
#(
  parameter int KEY_DOMAIN = KEY_DOMAIN_DEF,
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int GEN_WIDTH  = GEN_WIDTH_DEF,
  parameter int KEY_DIMS   = KEY_DIMS_DEF,
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int IDX_W     = (KEY_DOMAIN > 1) ? $clog2(KEY_DOMAIN) : 1,
  localparam int LIVE_W    = $clog2(NUM_SLOTS + 1),
  localparam int CNT_W     = $clog2(KEY_DOMAIN + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ACT_W-1:0]     action,
  input  logic [MIN_W-1:0]     key_first,
  input  logic [MIN_W-1:0]     key_second,
  input  logic [MIN_W-1:0]     key_third,
  input  logic [SLOT_W-1:0]    token_slot,
  input  logic [GEN_WIDTH-1:0] token_generation,
  output logic                 done,
  output logic [STAT_W-1:0]    status,
  output logic [SLOT_W-1:0]    granted_slot,
  output logic [GEN_WIDTH-1:0] granted_generation,
  output logic [IDX_W-1:0]     dense_key_index,
  output logic [LIVE_W-1:0]    live_count,
  output logic [CNT_W-1:0]     ever_bound_count,
  output logic [CNT_W-1:0]     completed_count,
  output logic                 keys_closed_flag,
  output logic                 aborted_flag,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int ENTRY_W = ACT_W + SLOT_W + GEN_WIDTH + IDX_W + STAT_W;

  // Configuration registers; dimension settings travel as one array of structs.
  dim_cfg_t              dims [NUM_DIMS];
  logic [SIU_W-1:0]      siu;
  reg_addr_t             reg_sel;
  logic                  cfg_wr;

  logic                  accept;
  logic                  front_busy;
  logic                  clearing;
  logic                  push, pop, q_empty, q_full;
  logic [ENTRY_W-1:0]    push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = reg_addr_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims[0] <= '{min: '0, card: CARD_W'(1024)};
      dims[1] <= '{min: '0, card: CARD_W'(1)};
      dims[2] <= '{min: '0, card: CARD_W'(1)};
      siu     <= SIU_W'(256);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MIN0:  dims[0].min  <= pwdata;
        REG_CARD0: dims[0].card <= pwdata[CARD_W-1:0];
        REG_MIN1:  dims[1].min  <= pwdata;
        REG_CARD1: dims[1].card <= pwdata[CARD_W-1:0];
        REG_MIN2:  dims[2].min  <= pwdata;
        REG_CARD2: dims[2].card <= pwdata[CARD_W-1:0];
        REG_SIU:   siu          <= pwdata[SIU_W-1:0];
        default:   siu          <= siu;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN0:  prdata = dims[0].min;
      REG_CARD0: prdata = 32'(dims[0].card);
      REG_MIN1:  prdata = dims[1].min;
      REG_CARD1: prdata = 32'(dims[1].card);
      REG_MIN2:  prdata = dims[2].min;
      REG_CARD2: prdata = 32'(dims[2].card);
      REG_SIU:   prdata = 32'(siu);
      default:   prdata = '0;
    endcase
  end

  // The front end is held off during the clearing sweep so no item reaches the
  // back end before the records are initialized.
  assign busy   = front_busy || clearing;
  assign accept = start && !busy;

  gksb_front #(
    .KEY_DOMAIN (KEY_DOMAIN),
    .KEY_DIMS   (KEY_DIMS),
    .GEN_WIDTH  (GEN_WIDTH),
    .SLOT_W     (SLOT_W),
    .IDX_W      (IDX_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .action           (action),
    .key_first        (key_first),
    .key_second       (key_second),
    .key_third        (key_third),
    .token_slot       (token_slot),
    .token_generation (token_generation),
    .dims             (dims),
    .q_full           (q_full),
    .front_busy       (front_busy),
    .push             (push),
    .push_data        (push_data)
  );

  gksb_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_empty   (q_empty),
    .q_full    (q_full)
  );

  gksb_back #(
    .KEY_DOMAIN (KEY_DOMAIN),
    .NUM_SLOTS  (NUM_SLOTS),
    .GEN_WIDTH  (GEN_WIDTH),
    .SLOT_W     (SLOT_W),
    .IDX_W      (IDX_W),
    .LIVE_W     (LIVE_W),
    .CNT_W      (CNT_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .q_empty            (q_empty),
    .q_data             (pop_data),
    .siu                (siu),
    .pop                (pop),
    .clearing           (clearing),
    .done               (done),
    .status             (status),
    .granted_slot       (granted_slot),
    .granted_generation (granted_generation),
    .dense_key_index    (dense_key_index),
    .live_count         (live_count),
    .ever_bound_count   (ever_bound_count),
    .completed_count    (completed_count),
    .keys_closed_flag   (keys_closed_flag),
    .aborted_flag       (aborted_flag)
  );

endmodule
